/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

/* hw/rtl/hsfr_pkg.sv */
// Shared types and constants of the serial frame receiver.
`timescale 1ns / 1ps
package hsfr_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int PLEN_W       = 6;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int HDR_BYTES    = 5;

  localparam logic [7:0] TERM_BYTE   = 8'hFF;
  localparam logic [7:0] CODE_ACK    = 8'h01;
  localparam logic [7:0] CODE_TOUCH  = 8'h65;
  localparam logic [7:0] CODE_PAGE   = 8'h66;
  localparam logic [7:0] CODE_STRING = 8'h70;
  localparam logic [7:0] CODE_NUMBER = 8'h71;
  localparam logic [7:0] CODE_ERRMAX = 8'h24;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FT_UNKNOWN = 3'd0,
    FT_ACK     = 3'd1,
    FT_TOUCH   = 3'd2,
    FT_PAGE    = 3'd3,
    FT_STRING  = 3'd4,
    FT_NUMBER  = 3'd5,
    FT_ERROR   = 3'd6
  } ftype_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_RD,
    S_WR
  } state_t;

  // One classified frame or status event, front to back.
  typedef struct packed {
    status_t              status;
    ftype_t               ftype;
    logic [7:0]           code;
    logic [7:0]           page;
    logic [7:0]           comp;
    logic [7:0]           evt;
    logic signed [31:0]   number;
    logic [PLEN_W-1:0]    plen;
  } cmd_t;

  // One result item.
  typedef struct packed {
    status_t              status;
    logic                 is_payload;
    ftype_t               ftype;
    logic [7:0]           code;
    logic [7:0]           page;
    logic [7:0]           comp;
    logic [7:0]           evt;
    logic signed [31:0]   number;
    logic [PLEN_W-1:0]    plen;
    logic [7:0]           data;
    logic                 last;
  } res_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* hw/rtl/hmi_serial_frame_receiver.sv */
// Top level of the display panel serial frame receiver.
//
//   channel  | handshake     | payload
//   ---------+---------------+-------------------------------------------
//   input    | push / full   | rx_byte
//   result   | empty / pop   | status .. last (eleven result fields)
//
// A byte that does not close a frame is taken whenever push is high and full is low.
// A closing byte queues a command; an idle back pops it, then registers its header.
// Payload bytes follow, each read from the frame buffer RAM through its
// registered port and then loaded; full stays high until the run is done.
// No clearing pass after reset; only counters, pointers, state and flags are reset.
// A stalled result holds the run; up to four commands queue, none during a payload run.
`timescale 1ns / 1ps
module hmi_serial_frame_receiver (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic               is_payload,
  output logic [2:0]         frame_type,
  output logic [7:0]         frame_code,
  output logic [7:0]         page_id,
  output logic [7:0]         component_id,
  output logic [7:0]         touch_event,
  output logic signed [31:0] number_value,
  output logic [5:0]         payload_length,
  output logic [7:0]         data_byte,
  output logic               last
);
  import hsfr_pkg::*;

  logic              q_push;
  logic              q_pop;
  cmd_t              q_wdata;
  cmd_t              q_rdata;
  qstat_t            q_stat;
  logic              pay_done;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  res_t              res;

  hsfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .rx_byte  (rx_byte),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_stat   (q_stat),
    .pay_done (pay_done),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  hsfr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  hsfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rdata  (q_rdata),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .pay_done (pay_done),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign status         = res.status;
  assign is_payload     = res.is_payload;
  assign frame_type     = res.ftype;
  assign frame_code     = res.code;
  assign page_id        = res.page;
  assign component_id   = res.comp;
  assign touch_event    = res.evt;
  assign number_value   = res.number;
  assign payload_length = res.plen;
  assign data_byte      = res.data;
  assign last           = res.last;

endmodule

/* hw/rtl/hsfr_queue.sv */
// Short command queue between the front and the back.
`timescale 1ns / 1ps
module hsfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hsfr_pkg::cmd_t wdata,
  input  logic          pop,
  output hsfr_pkg::cmd_t rdata,
  output hsfr_pkg::qstat_t stat
);
  import hsfr_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/hsfr_front.sv */
// Front: frame buffer, terminator detection and frame classification.
`timescale 1ns / 1ps
module hsfr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 rx_byte,
  output logic                       q_push,
  output hsfr_pkg::cmd_t             q_wdata,
  input  hsfr_pkg::qstat_t           q_stat,
  input  logic                       pay_done,
  input  logic [hsfr_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import hsfr_pkg::*;

  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       hdr_bytes [HDR_BYTES];
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [1:0]       ff_run;
  logic [1:0]       ff_run_next;
  logic             pend;
  logic             accept;
  logic             overflow;
  logic             frame_end;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] n;
  cmd_t             cmd;

  assign full     = q_stat.full || pend;
  assign accept   = push && !full;
  assign overflow = (fill == CNT_W'(BUFFER_DEPTH));
  assign len      = fill + CNT_W'(1);
  assign n        = len - CNT_W'(3);

  always_comb begin
    ff_run_next = '0;
    if (rx_byte == TERM_BYTE) begin
      ff_run_next = (ff_run == 2'd3) ? 2'd3 : ff_run + 2'd1;
    end
    frame_end = !overflow && (ff_run_next == 2'd3);
    fill_next = (overflow || frame_end) ? '0 : len;
  end

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    cmd.ftype  = FT_UNKNOWN;
    if (overflow) begin
      cmd.status = ST_OVERFLOW;
    end else if (len == CNT_W'(3)) begin
      cmd.status = ST_SHORT;
    end else begin
      cmd.code = hdr_bytes[0];
      if (hdr_bytes[0] == CODE_ACK && n == CNT_W'(1)) begin
        cmd.ftype = FT_ACK;
      end else if (hdr_bytes[0] == CODE_TOUCH && n >= CNT_W'(4)) begin
        cmd.ftype = FT_TOUCH;
        cmd.page  = hdr_bytes[1];
        cmd.comp  = hdr_bytes[2];
        cmd.evt   = hdr_bytes[3];
      end else if (hdr_bytes[0] == CODE_PAGE && n >= CNT_W'(2)) begin
        cmd.ftype = FT_PAGE;
        cmd.page  = hdr_bytes[1];
      end else if (hdr_bytes[0] == CODE_STRING) begin
        cmd.ftype = FT_STRING;
        cmd.plen  = PLEN_W'(n - CNT_W'(1));
      end else if (hdr_bytes[0] == CODE_NUMBER && n >= CNT_W'(5)) begin
        cmd.ftype  = FT_NUMBER;
        cmd.number = {hdr_bytes[4], hdr_bytes[3], hdr_bytes[2], hdr_bytes[1]};
      end else if (hdr_bytes[0] <= CODE_ERRMAX) begin
        cmd.ftype = FT_ERROR;
      end else if (n > CNT_W'(1)) begin
        cmd.plen = PLEN_W'(n - CNT_W'(1));
      end
    end
  end

  assign q_push  = accept && (overflow || frame_end);
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (accept && !overflow) begin
      mem[fill[ADDR_W-1:0]] <= rx_byte;
      if (fill < CNT_W'(HDR_BYTES)) begin
        hdr_bytes[fill[2:0]] <= rx_byte;
      end
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      ff_run <= '0;
      pend   <= 1'b0;
    end else begin
      if (accept) begin
        fill   <= fill_next;
        ff_run <= (overflow || frame_end) ? 2'd0 : ff_run_next;
      end
      if (q_push && cmd.plen != '0) begin
        pend <= 1'b1;
      end else if (pay_done) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/hsfr_back.sv */
// Back: emits the header and the payload run of each queued frame.
`timescale 1ns / 1ps
module hsfr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  hsfr_pkg::cmd_t              q_rdata,
  input  hsfr_pkg::qstat_t            q_stat,
  output logic                        q_pop,
  output logic [hsfr_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        pay_done,
  output logic                        empty,
  input  logic                        pop,
  output hsfr_pkg::res_t              res
);
  import hsfr_pkg::*;

  state_t            state;
  state_t            state_next;
  cmd_t              cur;
  logic [PLEN_W-1:0] idx;
  logic              out_valid;
  logic              out_free;
  logic              ld_hdr;
  logic              ld_pay;
  logic              is_last;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign is_last  = (idx == cur.plen);
  assign rd_addr  = ADDR_W'(idx);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!q_stat.empty) state_next = S_HDR;
      S_HDR:   if (out_free) state_next = (cur.plen == '0) ? S_IDLE : S_RD;
      S_RD:    state_next = S_WR;
      S_WR:    if (out_free) state_next = is_last ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = 1'b0;
    ld_hdr = 1'b0;
    ld_pay = 1'b0;
    case (state)
      S_IDLE:  q_pop  = !q_stat.empty;
      S_HDR:   ld_hdr = out_free;
      S_WR:    ld_pay = out_free;
      default: q_pop  = 1'b0;
    endcase
    pay_done = ld_pay && is_last;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_rdata;
    if (ld_hdr) begin
      idx            <= PLEN_W'(1);
      res.status     <= cur.status;
      res.is_payload <= 1'b0;
      res.ftype      <= cur.ftype;
      res.code       <= cur.code;
      res.page       <= cur.page;
      res.comp       <= cur.comp;
      res.evt        <= cur.evt;
      res.number     <= cur.number;
      res.plen       <= cur.plen;
      res.data       <= '0;
      res.last       <= (cur.plen == '0);
    end else if (ld_pay) begin
      idx            <= idx + PLEN_W'(1);
      res.status     <= ST_OK;
      res.is_payload <= 1'b1;
      res.ftype      <= cur.ftype;
      res.code       <= cur.code;
      res.page       <= '0;
      res.comp       <= '0;
      res.evt        <= '0;
      res.number     <= '0;
      res.plen       <= cur.plen;
      res.data       <= rd_data;
      res.last       <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld_hdr || ld_pay) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/hsfr_checker.sv */
// Port-level checker of the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsfr_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         status,
  input logic               is_payload,
  input logic [7:0]         page_id,
  input logic signed [31:0] number_value,
  input logic [5:0]         payload_length,
  input logic [7:0]         data_byte,
  input logic               last
);
  import hsfr_pkg::*;

  `ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(data_byte) && $stable(last))
  `ASSERT_IMPL(a_status_single, clk, rst, !empty && status != 2'(ST_OK), last && !is_payload)
  `ASSERT_IMPL(a_payload_ok, clk, rst, !empty && is_payload, status == 2'(ST_OK) && payload_length != 6'd0)
  `ASSERT_IMPL(a_bare_header_last, clk, rst, !empty && !is_payload && payload_length == 6'd0, last)
  `ASSERT_IMPL(a_payload_zeroes, clk, rst, !empty && is_payload, page_id == 8'd0 && number_value == 32'sd0)

endmodule

bind hmi_serial_frame_receiver hsfr_checker u_hsfr_checker (.*);
